### hw/rtl/conv2d_3x3_valid_assert.svh
// assertion macros for the 3x3 convolution block
`ifndef CONV2D_3X3_VALID_ASSERT_SVH
`define CONV2D_3X3_VALID_ASSERT_SVH

`ifndef SYNTHESIS
`define C2D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2d assertion failed");
`define C2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2d assertion failed");
`else
`define C2D_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define C2D_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/c2d_pkg.sv
// types and constants shared by the 3x3 convolution block
`timescale 1ns / 1ps
package c2d_pkg;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 8;
    localparam int SUM_W      = 20;
    localparam int SIZE_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int TAPS       = 3;
    localparam int MIN_SIZE   = 3;
    localparam int WIN_EDGE   = 2;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    localparam int PROD_W     = PIX_W + COEF_W + 1;
    localparam int ROW_W      = PROD_W + 2;
    localparam int TOT_W      = ROW_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERN_TOP,
        REG_KERN_MID,
        REG_KERN_BOT,
        REG_WIDTH,
        REG_HEIGHT
    } t_cfg_reg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pix_word;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    frame_last;
    } t_res_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_word;
endpackage

### hw/rtl/c2d_stream_if.sv
// valid/ready channel carrying one word
`timescale 1ns / 1ps
interface c2d_stream_if #(
    parameter type t_word = logic [7:0]
) ();
    logic  valid;
    logic  ready;
    t_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/conv2d_3x3_valid.sv
// 3x3 valid cross-correlation over a raster pixel stream
//
// channels: i_pix takes one pixel word (pixel, frame_start) in raster order,
// o_res gives one result word (sum, frame_last) per window fully inside the
// image, in row-major order, and i_cfg writes the kernel rows and the image
// size by register index; the user must do so only while the block is idle,
// which the block itself does not enforce; i_cfg is ready out of reset.
// throughput: one pixel per cycle while i_pix.ready is high; two line stores
// in single-port-write, read-first memories are read at the pixel's column and
// written back, with the upper store updated in the following cycle and
// forwarded on a column repeat. steps: store read, window shift, nine
// products, row sums, final add. results pass through an 8-word output queue;
// i_pix.ready falls when the queue plus the words still in the pipeline would
// fill it, so a stalled receiver holds the stream without losing a word.
// reset: position returns to row 0 column 0, kernel clears, size goes to
// 5x5, queue and pipeline empty; line store contents are kept as they are.
`timescale 1ns / 1ps
`include "conv2d_3x3_valid_assert.svh"
module conv2d_3x3_valid #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input logic i_clk,
    input logic i_rst_n,
    c2d_stream_if.sink   i_pix,
    c2d_stream_if.source o_res,
    c2d_stream_if.sink   i_cfg
);
    import c2d_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WB = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
    localparam int HB = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

    // configuration
    logic [CFG_DATA_W-1:0] r_kern [TAPS];
    logic [SIZE_W-1:0]     r_width;
    logic [SIZE_W-1:0]     r_height;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kern[0] <= '0;
            r_kern[1] <= '0;
            r_kern[2] <= '0;
            r_width   <= SIZE_W'(5);
            r_height  <= SIZE_W'(5);
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                REG_KERN_TOP: r_kern[0] <= i_cfg.payload.data;
                REG_KERN_MID: r_kern[1] <= i_cfg.payload.data;
                REG_KERN_BOT: r_kern[2] <= i_cfg.payload.data;
                REG_WIDTH:    r_width   <= i_cfg.payload.data[SIZE_W-1:0];
                REG_HEIGHT:   r_height  <= i_cfg.payload.data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // size clamp
    logic [WB-1:0] w_ext, w_eff;
    logic [HB-1:0] h_ext, h_eff;
    logic [CW-1:0] wm1;
    logic [RW-1:0] hm1;

    always_comb begin
        w_ext = WB'(r_width);
        h_ext = HB'(r_height);
        if (w_ext < WB'(MIN_SIZE)) begin
            w_eff = WB'(MIN_SIZE);
        end else if (w_ext > WB'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext < HB'(MIN_SIZE)) begin
            h_eff = HB'(MIN_SIZE);
        end else if (h_ext > HB'(MAX_HEIGHT)) begin
            h_eff = HB'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
        wm1 = CW'(w_eff - WB'(1));
        hm1 = RW'(h_eff - HB'(1));
    end

    // position
    logic [CW-1:0] r_col, n_col, cur_col;
    logic [RW-1:0] r_row, n_row, cur_row;
    logic          row_end, img_end, produce, acc;

    assign acc = i_pix.valid & i_pix.ready;

    always_comb begin
        cur_col = i_pix.payload.frame_start ? '0 : r_col;
        cur_row = i_pix.payload.frame_start ? '0 : r_row;
        if (cur_col > wm1) begin
            cur_col = wm1;
        end
        if (cur_row > hm1) begin
            cur_row = hm1;
        end
        row_end = (cur_col == wm1);
        img_end = row_end && (cur_row == hm1);
        produce = (cur_row >= RW'(WIN_EDGE)) && (cur_col >= CW'(WIN_EDGE));
        if (img_end) begin
            n_col = '0;
            n_row = '0;
        end else if (row_end) begin
            n_col = '0;
            n_row = cur_row + RW'(1);
        end else begin
            n_col = cur_col + CW'(1);
            n_row = cur_row;
        end
    end

    // pipeline control
    logic            r_v1, r_v2, r_v3, r_v4, r_fwd;
    logic            r_prod1, r_last1, r_last2, r_last3, r_last4;
    logic [FIFO_AW:0] r_cnt, occ, fill;
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic            pop;

    assign occ   = (FIFO_AW+1)'(r_v1) + (FIFO_AW+1)'(r_v2)
                 + (FIFO_AW+1)'(r_v3) + (FIFO_AW+1)'(r_v4);
    assign fill  = r_cnt + occ;
    assign i_pix.ready = i_rst_n && (fill < (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop   = o_res.valid & o_res.ready;

    logic [CW-1:0] r_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_fwd    <= 1'b0;
            r_cnt    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_v1  <= acc;
            r_fwd <= acc && r_v1 && (cur_col == r_c1);
            r_v2  <= r_v1 && r_prod1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            if (r_v4) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_cnt <= r_cnt + (FIFO_AW+1)'(r_v4) - (FIFO_AW+1)'(pop);
        end
    end

    // line stores, read first, upper written back in the cycle after its read
    logic [PIX_W-1:0] r_mem_up [MAX_WIDTH];
    logic [PIX_W-1:0] r_mem_lo [MAX_WIDTH];
    logic [PIX_W-1:0] r_up_rd, r_lo_rd, r_fwd_data, r_px1, up_px;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_up_rd            <= r_mem_up[cur_col];
            r_lo_rd            <= r_mem_lo[cur_col];
            r_mem_lo[cur_col]  <= i_pix.payload.pixel;
            r_c1               <= cur_col;
            r_px1              <= i_pix.payload.pixel;
            r_prod1            <= produce;
            r_last1            <= img_end;
            r_fwd_data         <= r_lo_rd;
        end
        if (r_v1) begin
            r_mem_up[r_c1] <= r_lo_rd;
        end
    end

    assign up_px = r_fwd ? r_fwd_data : r_up_rd;

    // window and arithmetic
    logic [PIX_W-1:0]         r_win  [TAPS*TAPS];
    logic signed [PROD_W-1:0] r_prod [TAPS*TAPS];
    logic signed [ROW_W-1:0]  r_rsum [TAPS];
    logic signed [TOT_W-1:0]  total;
    t_res_word                r_fifo [FIFO_DEPTH];

    assign total = TOT_W'(r_rsum[0]) + TOT_W'(r_rsum[1]) + TOT_W'(r_rsum[2]);

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            for (int i = 0; i < TAPS; i++) begin
                r_win[TAPS*i]     <= r_win[TAPS*i + 1];
                r_win[TAPS*i + 1] <= r_win[TAPS*i + 2];
            end
            r_win[2] <= up_px;
            r_win[5] <= r_lo_rd;
            r_win[8] <= r_px1;
            r_last2  <= r_last1;
        end
        if (r_v2) begin
            for (int k = 0; k < TAPS; k++) begin
                for (int j = 0; j < TAPS; j++) begin
                    r_prod[TAPS*k + j] <= PROD_W'($signed({1'b0, r_win[TAPS*k + j]})
                                        * $signed(r_kern[k][COEF_W*j +: COEF_W]));
                end
            end
            r_last3 <= r_last2;
        end
        if (r_v3) begin
            for (int k = 0; k < TAPS; k++) begin
                r_rsum[k] <= ROW_W'(r_prod[TAPS*k]) + ROW_W'(r_prod[TAPS*k + 1])
                           + ROW_W'(r_prod[TAPS*k + 2]);
            end
            r_last4 <= r_last3;
        end
        if (r_v4) begin
            r_fifo[r_wr_ptr].sum        <= total[SUM_W-1:0];
            r_fifo[r_wr_ptr].frame_last <= r_last4;
        end
    end

    assign o_res.valid   = (r_cnt != '0);
    assign o_res.payload = r_fifo[r_rd_ptr];

    `C2D_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1,
        fill <= (FIFO_AW+1)'(FIFO_DEPTH))
    `C2D_ASSERT_NOW(a_fwd_live, i_clk, i_rst_n, r_fwd, r_v1)
    `C2D_ASSERT_NEXT(a_start_col, i_clk, i_rst_n, acc && i_pix.payload.frame_start,
        r_c1 == '0)
    `C2D_ASSERT_NEXT(a_hold_count, i_clk, i_rst_n, o_res.valid && !o_res.ready && !r_v4,
        r_cnt == $past(r_cnt))
endmodule
